// ===== sv/fud_pkg.sv =====
package fud_pkg;

	// characters with a meaning of their own in a form body
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// result kinds
	localparam logic [1:0] KIND_KEY      = 2'd0;
	localparam logic [1:0] KIND_VALUE    = 2'd1;
	localparam logic [1:0] KIND_PAIR_END = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
	localparam logic [1:0] ERR_NO_EQUALS  = 2'd2;

	// escape progress
	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	// decoder state between beats
	typedef struct packed {
		logic       in_value;
		logic [1:0] percent_phase;
		logic [3:0] high_nibble;
		logic       pair_nonempty;
		logic       held_key_error;
		logic       error_sent;
	} state_t;

	// one input beat
	typedef struct packed {
		logic [7:0] body_byte;
		logic       has_byte;
		logic       end_of_body;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [1:0] error_code;
		logic       body_done;
	} result_t;

endpackage

// ===== sv/fud_step.sv =====
module fud_step (
	input  fud_pkg::state_t  st,
	input  fud_pkg::item_t   item,
	output fud_pkg::state_t  st_next,
	output logic [1:0]       res_count,
	output fud_pkg::result_t res0,
	output fud_pkg::result_t res1
);

	logic            hex_ok;
	logic [3:0]      hex_val;
	logic [1:0]      dec_phase;
	logic [3:0]      dec_high;
	logic            dec_byte;
	logic            dec_bad;
	logic [7:0]      dec_data;
	logic            em_a;
	logic            em_b;
	fud_pkg::result_t res_a;
	fud_pkg::result_t res_b;
	fud_pkg::state_t  nx;

	// hex digit of either case
	always_comb begin
		hex_ok  = 1'b0;
		hex_val = item.body_byte[3:0];
		if (item.body_byte >= 8'h30 && item.body_byte <= 8'h39) begin
			hex_ok = 1'b1;
		end else if ((item.body_byte >= 8'h41 && item.body_byte <= 8'h46) ||
			(item.body_byte >= 8'h61 && item.body_byte <= 8'h66)) begin
			hex_ok  = 1'b1;
			hex_val = item.body_byte[3:0] + 4'd9;
		end
	end

	// plus, percent and escape digits
	always_comb begin
		dec_phase = st.percent_phase;
		dec_high  = st.high_nibble;
		dec_byte  = 1'b0;
		dec_bad   = 1'b0;
		dec_data  = item.body_byte;
		if (st.percent_phase == fud_pkg::PH_NONE) begin
			if (item.body_byte == fud_pkg::CH_PERCENT) begin
				dec_phase = fud_pkg::PH_PCT;
			end else begin
				dec_byte = 1'b1;
				if (item.body_byte == fud_pkg::CH_PLUS) begin
					dec_data = fud_pkg::CH_SPACE;
				end
			end
		end else if (!hex_ok) begin
			dec_bad   = 1'b1;
			dec_phase = fud_pkg::PH_NONE;
			dec_high  = 4'd0;
		end else if (st.percent_phase == fud_pkg::PH_PCT) begin
			dec_high  = hex_val;
			dec_phase = fud_pkg::PH_HIGH;
		end else begin
			dec_byte  = 1'b1;
			dec_data  = {st.high_nibble, hex_val};
			dec_phase = fud_pkg::PH_NONE;
			dec_high  = 4'd0;
		end
	end

	// pair handling, body end and result assembly
	always_comb begin
		nx    = st;
		em_a  = 1'b0;
		em_b  = 1'b0;
		res_a = '0;
		res_b = '0;
		if (item.has_byte && !st.error_sent) begin
			if (item.body_byte == fud_pkg::CH_AMP) begin
				if (st.pair_nonempty) begin
					em_a = 1'b1;
					if (!st.in_value) begin
						res_a.kind       = fud_pkg::KIND_ERROR;
						res_a.error_code = fud_pkg::ERR_NO_EQUALS;
						nx.error_sent    = 1'b1;
					end else if (st.percent_phase != fud_pkg::PH_NONE) begin
						res_a.kind       = fud_pkg::KIND_ERROR;
						res_a.error_code = fud_pkg::ERR_BAD_ESCAPE;
						nx.error_sent    = 1'b1;
					end else begin
						res_a.kind = fud_pkg::KIND_PAIR_END;
					end
				end
				nx.in_value       = 1'b0;
				nx.percent_phase  = fud_pkg::PH_NONE;
				nx.high_nibble    = 4'd0;
				nx.pair_nonempty  = 1'b0;
				nx.held_key_error = 1'b0;
			end else begin
				nx.pair_nonempty = 1'b1;
				if (!st.in_value) begin
					if (item.body_byte == fud_pkg::CH_EQUALS) begin
						if (st.held_key_error || st.percent_phase != fud_pkg::PH_NONE) begin
							em_a             = 1'b1;
							res_a.kind       = fud_pkg::KIND_ERROR;
							res_a.error_code = fud_pkg::ERR_BAD_ESCAPE;
							nx.error_sent    = 1'b1;
						end else begin
							nx.in_value = 1'b1;
						end
					end else if (!st.held_key_error) begin
						nx.percent_phase = dec_phase;
						nx.high_nibble   = dec_high;
						if (dec_bad) begin
							nx.held_key_error = 1'b1;
						end else if (dec_byte) begin
							em_a            = 1'b1;
							res_a.kind      = fud_pkg::KIND_KEY;
							res_a.data_byte = dec_data;
						end
					end
				end else begin
					nx.percent_phase = dec_phase;
					nx.high_nibble   = dec_high;
					if (dec_bad) begin
						em_a             = 1'b1;
						res_a.kind       = fud_pkg::KIND_ERROR;
						res_a.error_code = fud_pkg::ERR_BAD_ESCAPE;
						nx.error_sent    = 1'b1;
					end else if (dec_byte) begin
						em_a            = 1'b1;
						res_a.kind      = fud_pkg::KIND_VALUE;
						res_a.data_byte = dec_data;
					end
				end
			end
		end
		if (item.end_of_body) begin
			// close the last pair, looking at the state this beat left
			if (!nx.error_sent && nx.pair_nonempty) begin
				em_b = 1'b1;
				if (!nx.in_value) begin
					res_b.kind       = fud_pkg::KIND_ERROR;
					res_b.error_code = fud_pkg::ERR_NO_EQUALS;
				end else if (nx.percent_phase != fud_pkg::PH_NONE) begin
					res_b.kind       = fud_pkg::KIND_ERROR;
					res_b.error_code = fud_pkg::ERR_BAD_ESCAPE;
				end else begin
					res_b.kind = fud_pkg::KIND_PAIR_END;
				end
			end
			// end marker when nothing else came out
			if (!em_a && !em_b) begin
				em_b             = 1'b1;
				res_b.kind       = fud_pkg::KIND_ERROR;
				res_b.error_code = fud_pkg::ERR_NONE;
			end
			if (em_b) begin
				res_b.body_done = 1'b1;
			end else begin
				res_a.body_done = 1'b1;
			end
			nx = '0;
		end
	end

	assign st_next   = nx;
	assign res_count = {1'b0, em_a} + {1'b0, em_b};
	assign res0      = em_a ? res_a : res_b;
	assign res1      = res_b;

endmodule

// ===== sv/fud_out_buf.sv =====
module fud_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [1:0]       push_count,
	input  fud_pkg::result_t push0,
	input  fud_pkg::result_t push1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output fud_pkg::result_t out_res
);

	logic [1:0]       count_q;
	logic [1:0]       count_n;
	logic [1:0]       base;
	logic             pop;
	fud_pkg::result_t r0_q;
	fud_pkg::result_t r1_q;
	fud_pkg::result_t r0_n;
	fud_pkg::result_t r1_n;

	assign pop       = (count_q != 2'd0) && out_ready;
	assign base      = count_q - {1'b0, pop};
	assign room      = (count_q == 2'd0) || (count_q == 2'd1 && out_ready);
	assign out_valid = (count_q != 2'd0);
	assign out_res   = r0_q;

	// shift out the head beat, then append this beat's results
	always_comb begin
		r0_n    = r0_q;
		r1_n    = r1_q;
		count_n = base;
		if (pop) begin
			r0_n = r1_q;
		end
		if (push && push_count != 2'd0) begin
			count_n = base + push_count;
			case (base)
				2'd0: begin
					r0_n = push0;
					r1_n = push1;
				end
				2'd1: begin
					r1_n = push0;
				end
				default: begin
					r1_n = r1_q;
				end
			endcase
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_n;
		end
	end

	// result slots
	always_ff @(posedge clk) begin
		r0_q <= r0_n;
		r1_q <= r1_n;
	end

endmodule

// ===== sv/form_urlencoded_decoder.sv =====
// form body decoder, one raw body byte per input beat
// slave side: s_axis_tdata holds the byte, s_axis_tuser says whether the byte is
// present (0 for an empty closing beat), s_axis_tlast marks the last beat of a body
// master side: one beat per result; m_axis_tuser gives the kind (key byte, value
// byte, pair end, error), m_axis_tdata the decoded byte and the error code, and
// m_axis_tlast marks the last result of a body
// an input beat is registered on acceptance in the input stage, then decoded and
// written into a two-slot result buffer, from which its first result shows on
// m_axis_tvalid
// throughput is one beat per cycle while the results fit in the buffer; a beat that
// gives two results (a byte on the closing beat of a body) holds the input back
// while the single result port drains the two-slot buffer
// beats that give no result never wait on the master side
// when the receiver stalls the buffer fills and s_axis_tready drops; nothing is lost
// reset clears the decoder state, the input stage and the result buffer
module form_urlencoded_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] body_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [9:8] error_code, rest zero
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast
);

	logic             valid_s1;
	fud_pkg::item_t   item_s1;
	fud_pkg::state_t  st_q;
	fud_pkg::state_t  st_next;
	logic [1:0]       res_count;
	fud_pkg::result_t res0;
	fud_pkg::result_t res1;
	fud_pkg::result_t out_res;
	logic             room;
	logic             advance;

	// the stage moves on when its results fit in the buffer
	assign advance       = valid_s1 && (res_count == 2'd0 || room);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage valid and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				st_q <= st_next;
			end
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.body_byte   <= s_axis_tdata;
			item_s1.has_byte    <= s_axis_tuser;
			item_s1.end_of_body <= s_axis_tlast;
		end
	end

	fud_step u_step (
		.st        (st_q),
		.item      (item_s1),
		.st_next   (st_next),
		.res_count (res_count),
		.res0      (res0),
		.res1      (res1)
	);

	fud_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance),
		.push_count (res_count),
		.push0      (res0),
		.push1      (res1),
		.room       (room),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	// result beat packing
	assign m_axis_tdata = {6'd0, out_res.error_code, out_res.data_byte};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.body_done;

endmodule

// ===== tb/form_urlencoded_decoder_checker.sv =====
module form_urlencoded_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] body_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // [7:0] data_byte, [9:8] error_code
	input  logic [1:0]  m_axis_tuser,  // [1:0] kind
	input  logic        m_axis_tlast,
	output int          failures,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// outcome of feeding one character to the escape decoder
	localparam int DEC_PENDING = 0;
	localparam int DEC_BYTE    = 1;
	localparam int DEC_BAD     = 2;

	// predicted decoder state
	logic       in_value;
	logic [1:0] esc_phase;
	logic [3:0] esc_high;
	logic       pair_open;
	logic       key_err_held;
	logic       err_reported;

	// results of the beat being predicted, and results still to arrive
	fud_pkg::result_t beat_out [2];
	int               beat_n;
	fud_pkg::result_t decoded_queue [$];
	fud_pkg::result_t want;

	function automatic void add_result(input logic [1:0] k, input logic [7:0] d,
			input logic [1:0] c);
		beat_out[beat_n] = '{kind: k, data_byte: d, error_code: c, body_done: 1'b0};
		beat_n++;
	endfunction

	function automatic void report_error(input logic [1:0] c);
		add_result(fud_pkg::KIND_ERROR, 8'h00, c);
		err_reported = 1'b1;
	endfunction

	function automatic void clear_pair();
		in_value     = 1'b0;
		esc_phase    = fud_pkg::PH_NONE;
		esc_high     = 4'h0;
		pair_open    = 1'b0;
		key_err_held = 1'b0;
	endfunction

	// a pair closed by '&' or by the end of the body
	function automatic void close_pair();
		if (!in_value) report_error(fud_pkg::ERR_NO_EQUALS);
		else if (esc_phase != fud_pkg::PH_NONE) report_error(fud_pkg::ERR_BAD_ESCAPE);
		else add_result(fud_pkg::KIND_PAIR_END, 8'h00, fud_pkg::ERR_NONE);
	endfunction

	// plus to space and percent escapes, one character at a time
	function automatic int unescape(input logic [7:0] b, output logic [7:0] res);
		logic [4:0] digit; // {is hex, value}
		res = 8'h00;
		if (esc_phase == fud_pkg::PH_NONE) begin
			if (b == fud_pkg::CH_PERCENT) begin
				esc_phase = fud_pkg::PH_PCT;
				return DEC_PENDING;
			end
			res = (b == fud_pkg::CH_PLUS) ? fud_pkg::CH_SPACE : b;
			return DEC_BYTE;
		end
		if (b >= "0" && b <= "9") digit = {1'b1, b[3:0]};
		else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) digit = {1'b1, b[3:0] + 4'd9};
		else digit = 5'd0;
		if (!digit[4]) begin
			esc_phase = fud_pkg::PH_NONE;
			esc_high  = 4'h0;
			return DEC_BAD;
		end
		if (esc_phase == fud_pkg::PH_PCT) begin
			esc_high  = digit[3:0];
			esc_phase = fud_pkg::PH_HIGH;
			return DEC_PENDING;
		end
		res       = {esc_high, digit[3:0]};
		esc_phase = fud_pkg::PH_NONE;
		esc_high  = 4'h0;
		return DEC_BYTE;
	endfunction

	// expected results of one accepted input beat
	function automatic void decode_beat(input logic [7:0] b, input logic has, input logic is_last);
		logic [7:0] res;
		int         st;
		beat_n = 0;
		if (has && !err_reported) begin
			if (b == fud_pkg::CH_AMP) begin
				if (pair_open) close_pair();
				clear_pair();
			end else begin
				pair_open = 1'b1;
				if (!in_value && b == fud_pkg::CH_EQUALS) begin
					// a key escape that went wrong is only reported once the '=' shows up
					if (key_err_held || esc_phase != fud_pkg::PH_NONE)
						report_error(fud_pkg::ERR_BAD_ESCAPE);
					else in_value = 1'b1;
				end else if (!in_value) begin
					if (!key_err_held) begin
						st = unescape(b, res);
						if (st == DEC_BAD) key_err_held = 1'b1;
						else if (st == DEC_BYTE) add_result(fud_pkg::KIND_KEY, res, fud_pkg::ERR_NONE);
					end
				end else begin
					st = unescape(b, res);
					if (st == DEC_BAD) report_error(fud_pkg::ERR_BAD_ESCAPE);
					else if (st == DEC_BYTE) add_result(fud_pkg::KIND_VALUE, res, fud_pkg::ERR_NONE);
				end
			end
		end
		if (is_last) begin
			if (!err_reported && pair_open) close_pair();
			// the closing beat always says something
			if (beat_n == 0) add_result(fud_pkg::KIND_ERROR, 8'h00, fud_pkg::ERR_NONE);
			beat_out[beat_n - 1].body_done = 1'b1;
			clear_pair();
			err_reported = 1'b0;
		end
		for (int i = 0; i < beat_n; i++) decoded_queue.push_back(beat_out[i]);
	endfunction

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pair();
			err_reported = 1'b0;
			decoded_queue.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_queue.size() == 0) begin
					if (failures < 10)
						$display("unexpected result beat: kind %0d data %04h last %0b",
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
					failures++;
				end else begin
					want = decoded_queue.pop_front();
					if (m_axis_tuser != want.kind ||
							m_axis_tdata != {6'b0, want.error_code, want.data_byte} ||
							m_axis_tlast != want.body_done) begin
						if (failures < 10) begin
							$display("result mismatch: expected kind %0d data %02h code %0d last %0b",
								want.kind, want.data_byte, want.error_code, want.body_done);
							$display("  got kind %0d tdata %04h last %0b",
								m_axis_tuser, m_axis_tdata, m_axis_tlast);
						end
						failures++;
					end
				end
			end
			outstanding = decoded_queue.size();
		end
	end

endmodule

// ===== tb/form_urlencoded_decoder_test.sv =====
module form_urlencoded_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AFTER     = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] body_byte
	logic        s_axis_tuser  = 1'b0;   // [0] has_byte
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [7:0] data_byte, [9:8] error_code
	logic [1:0]  m_axis_tuser;           // [1:0] kind
	logic        m_axis_tlast;

	int failures;
	int outstanding;
	int beats_in    = 0;
	int idle_cycles = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	bit hold_done   = 1'b0;

	logic [7:0] body_q [$];

	form_urlencoded_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	form_urlencoded_decoder_checker decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// input beat counter and watchdog on a stuck handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (s_axis_tvalid && s_axis_tready) beats_in++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("form_urlencoded_decoder_test: errors");
				$finish;
			end
		end
	end

	// receiver: stretches of differing stall patterns, one long hold-off
	initial begin
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 120);
			for (int ph = 0; ph < span; ph++) begin
				@(posedge clk);
				if (!hold_done && beats_in >= HOLD_AFTER) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end else begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= (ph % 4) != 3;
						2: m_axis_tready <= 1'($urandom_range(0, 1));
						default: m_axis_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// offer one beat, in bursts with gaps, and wait for it to be taken
	task automatic send_beat(input logic [7:0] b, input logic has, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= has;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		if (has) items_sent++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b1, last_at_end && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + {4'h0, v};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
		return b;
	endfunction

	// one piece of a key or value: plain, plus, escape, broken escape or any byte
	function automatic void append_token();
		string alnum;
		int    sel;
		alnum = "abcxyzABCXYZ0189-._~";
		sel = $urandom_range(0, 99);
		if (sel < 58) begin
			body_q.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
		end else if (sel < 68) begin
			body_q.push_back(fud_pkg::CH_PLUS);
		end else if (sel < 92) begin
			body_q.push_back(fud_pkg::CH_PERCENT);
			body_q.push_back(hex_char(4'($urandom_range(0, 15))));
			body_q.push_back(hex_char(4'($urandom_range(0, 15))));
		end else if (sel < 95) begin
			body_q.push_back(fud_pkg::CH_PERCENT);
			if ($urandom_range(0, 1)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
			body_q.push_back(non_hex_char());
		end else begin
			body_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// a random body: mostly well-formed pairs, some without '=', some noise
	task automatic send_form_body();
		int  npairs;
		int  sel;
		int  n;
		bit  end_on_byte;
		body_q.delete();
		npairs = $urandom_range(0, 4);
		if ($urandom_range(0, 9) == 0) body_q.push_back(fud_pkg::CH_AMP);
		for (int p = 0; p < npairs; p++) begin
			if (p > 0) begin
				body_q.push_back(fud_pkg::CH_AMP);
				if ($urandom_range(0, 9) == 0) body_q.push_back(fud_pkg::CH_AMP);
			end
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				n = $urandom_range(0, 4);
				repeat (n) append_token();
				body_q.push_back(fud_pkg::CH_EQUALS);
				n = $urandom_range(0, 5);
				repeat (n) append_token();
				if ($urandom_range(0, 6) == 0) begin
					body_q.push_back(fud_pkg::CH_EQUALS);
					append_token();
				end
			end else if (sel < 90) begin
				n = $urandom_range(1, 4);
				repeat (n) append_token();
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 5) == 0) body_q.push_back(fud_pkg::CH_AMP);
		end_on_byte = (body_q.size() > 0) && $urandom_range(0, 1);
		foreach (body_q[i]) begin
			if ($urandom_range(0, 24) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_beat(body_q[i], 1'b1, end_on_byte && (i == body_q.size() - 1));
		end
		if (!end_on_byte) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// reset, directed bodies, random bodies, drain and verdict
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// escapes in both cases, plus, later '=' literal, closing beat with a byte
		send_text("%4a=%6A+=", 1'b1);
		// pair closed by '&', then an empty closing beat
		send_text("ab&", 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		// bad key escape held until '=', with an empty beat in between
		send_beat(fud_pkg::CH_PERCENT, 1'b1, 1'b0);
		send_beat("z", 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(fud_pkg::CH_EQUALS, 1'b1, 1'b1);
		// pair without '=' at the end of the body
		send_text("x", 1'b1);
		// value escape cut short by '&'
		send_text("=%&", 1'b1);
		// body with no bytes at all
		send_beat(8'hFF, 1'b0, 1'b1);
		// byte extremes
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(fud_pkg::CH_EQUALS, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b1);

		while (items_sent < RANDOM_ITEMS) send_form_body();
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("form_urlencoded_decoder_test: clean");
		else
			$display("form_urlencoded_decoder_test: errors");
		$finish;
	end

endmodule
